/* rtl/core/ffba_pkg.sv */
// Package: shared constants, codes and types of the first-fit allocator.
package ffba_pkg;
	localparam int MAX_BLOCKS_DEF   = 256;
	localparam int HEADER_BYTES_DEF = 32;

	localparam logic [31:0] HEAP_LIMIT_RST  = 32'd1048576;
	localparam logic [31:0] MAX_REQUEST_RST = 32'd100000000;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_CALLOC  = 2'd1,
		REQ_FREE    = 2'd2,
		REQ_REALLOC = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SIZE  = 2'd1,
		ST_NOMEM = 2'd2,
		ST_NONE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MOV_NONE = 2'd0,
		MOV_ZERO = 2'd1,
		MOV_COPY = 2'd2
	} mover_t;

	typedef enum logic [1:0] {
		CFG_HEAP_BASE   = 2'd0,
		CFG_HEAP_LIMIT  = 2'd1,
		CFG_MAX_REQUEST = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] size;
		logic [31:0] count;
		logic [31:0] handle;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] address;
		logic [1:0]  mover_op;
		logic [31:0] mover_src;
		logic [31:0] mover_len;
		logic [8:0]  free_blocks;
		logic [31:0] free_bytes;
		logic [8:0]  used_blocks;
		logic [31:0] used_bytes;
		logic [31:0] meta_bytes;
	} rsp_word_t;
endpackage

/* rtl/core/ffba_if.sv */
// Interfaces: valid/ready channels for request and response words.
interface ffba_req_if import ffba_pkg::*; ();
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/first_fit_block_allocator_top.sv */
// Top level: first-fit allocator with sequenced table scan.
//
//  channel | dir | handshake     | word
//  req     | in  | valid/ready   | req_type, size, count, handle
//  rsp     | out | valid/ready   | status, address, mover op/src/len, stats
//  cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// An alloc scans the block table from the first entry, one registered read and one
// compare per step, and appends at the heap top if no free block fits; a moving
// realloc scans for the handle first and settles in two steps; calloc first waits on
// the multiplier.
// Reset empties the table at once through the block count; no clearing pass.
// The response sits in an output register; a stalled sink holds it and the
// next request is taken only after it leaves.
module first_fit_block_allocator_top import ffba_pkg::*; #(
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	ffba_req_if.sink    req,
	ffba_rsp_if.source  rsp
);
	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);
	localparam logic [32:0]   HDR  = 33'(HEADER_BYTES);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MUL   = 10'b0000000010,
		S_CHECK = 10'b0000000100,
		S_FRD   = 10'b0000001000,
		S_FCMP  = 10'b0000010000,
		S_GRD   = 10'b0000100000,
		S_GCMP  = 10'b0001000000,
		S_APP   = 10'b0010000000,
		S_FIN   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [31:0] heap_base_q, heap_limit_q, max_req_q;
	logic [CW-1:0] blk_cnt_q, free_cnt_q;
	logic [31:0] heap_used_q, free_bytes_q, used_bytes_q;

	// block table
	logic [31:0] mem_start [MAX_BLOCKS];
	logic [31:0] mem_size  [MAX_BLOCKS];
	logic        mem_free  [MAX_BLOCKS];
	logic [31:0] rd_start, rd_size;
	logic        rd_free;
	logic        we;
	logic [IW-1:0] wa, ra;
	logic [31:0] wd_start, wd_size;
	logic        wd_free;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_start[wa] <= wd_start;
			mem_size[wa]  <= wd_size;
			mem_free[wa]  <= wd_free;
		end
		rd_start <= mem_start[ra];
		rd_size  <= mem_size[ra];
		rd_free  <= mem_free[ra];
	end

	req_word_t   r_q;
	logic [31:0] need_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] k_q;
	logic [31:0] ksize_q;
	logic          grant_q;
	rsp_word_t   o_q;
	logic        ov_q;

	logic        mstart, mdone;
	logic [63:0] prod;

	ffba_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart),
		.a(req.data.size), .b(req.data.count), .done(mdone), .prod(prod)
	);

	assign req.ready = (state_q == S_IDLE) && !ov_q;
	assign mstart = req.valid && req.ready && (req.data.req_type == REQ_CALLOC);
	assign rsp.valid = ov_q;
	assign rsp.data  = o_q;
	assign ra = idx_q[IW-1:0];

	// heap top after a new block, checked against the limit
	logic [32:0] want;
	logic [33:0] reach;
	logic        over;
	assign want  = HDR + {1'b0, need_q};
	assign reach = {2'b00, heap_used_q} + {1'b0, want};
	assign over  = reach > {2'b00, heap_limit_q};

	always_comb begin
		we = 1'b0; wa = k_q; wd_start = rd_start; wd_size = rd_size; wd_free = 1'b1;
		if (state_q == S_GCMP && rd_free && rd_size >= need_q) begin
			we = 1'b1; wa = idx_q[IW-1:0]; wd_free = 1'b0;
		end else if (state_q == S_APP && idx_q == blk_cnt_q && blk_cnt_q != MAXB
				&& !over) begin
			we = 1'b1; wa = blk_cnt_q[IW-1:0];
			wd_start = heap_base_q + heap_used_q + HDR[31:0];
			wd_size = need_q; wd_free = 1'b0;
		end else if (state_q == S_FIN && r_q.req_type == REQ_FREE && o_q.status == ST_OK) begin
			we = 1'b1; wd_start = r_q.handle; wd_size = ksize_q;
		end else if (state_q == S_FIN && o_q.mover_op == MOV_COPY) begin
			we = 1'b1; wd_start = r_q.handle; wd_size = ksize_q;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0; heap_limit_q <= HEAP_LIMIT_RST; max_req_q <= MAX_REQUEST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEAP_BASE:   heap_base_q  <= cfg_data;
				CFG_HEAP_LIMIT:  heap_limit_q <= cfg_data;
				CFG_MAX_REQUEST: max_req_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ov_q <= 1'b0;
			blk_cnt_q <= '0; free_cnt_q <= '0;
			heap_used_q <= '0; free_bytes_q <= '0; used_bytes_q <= '0;
		end else begin
			if (ov_q && rsp.ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					r_q <= req.data;
					need_q <= req.data.size;
					idx_q <= '0;
					grant_q <= 1'b0;
					o_q.status <= ST_NONE; o_q.address <= '0; o_q.mover_op <= MOV_NONE;
					o_q.mover_src <= '0; o_q.mover_len <= '0;
					state_q <= (req.data.req_type == REQ_CALLOC) ? S_MUL : S_CHECK;
				end
				S_MUL: if (mdone) begin
					need_q <= prod[31:0];
					if (r_q.size == 0 || r_q.count == 0 || prod > {32'd0, max_req_q}) begin
						o_q.status <= ST_SIZE; state_q <= S_FIN;
					end else begin
						grant_q <= 1'b1; state_q <= S_GRD;
					end
				end
				S_CHECK: begin
					if (r_q.req_type == REQ_FREE) begin
						state_q <= (r_q.handle == 0) ? S_FIN : S_FRD;
					end else if (r_q.size == 0 || r_q.size > max_req_q) begin
						o_q.status <= ST_SIZE; state_q <= S_FIN;
					end else if (r_q.req_type == REQ_ALLOC || r_q.handle == 0) begin
						grant_q <= 1'b1; state_q <= S_GRD;
					end else state_q <= S_FRD;
				end
				S_FRD: state_q <= (idx_q == blk_cnt_q) ? S_FIN : S_FCMP;
				S_FCMP: begin
					if (rd_start == r_q.handle) begin
						k_q <= idx_q[IW-1:0]; ksize_q <= rd_size;
						if (rd_free) state_q <= S_FIN;
						else if (r_q.req_type == REQ_FREE) begin
							o_q.status <= ST_OK; state_q <= S_FIN;
						end else if (r_q.size <= rd_size) begin
							o_q.status <= ST_OK; o_q.address <= r_q.handle; state_q <= S_FIN;
						end else begin
							grant_q <= 1'b1;
							idx_q <= '0; state_q <= S_GRD;
						end
					end else begin
						idx_q <= idx_q + 1'b1; state_q <= S_FRD;
					end
				end
				S_GRD: state_q <= (idx_q == blk_cnt_q) ? S_APP : S_GCMP;
				S_GCMP: begin
					if (rd_free && rd_size >= need_q) begin
						free_cnt_q <= free_cnt_q - 1'b1;
						free_bytes_q <= free_bytes_q - rd_size;
						o_q.status <= ST_OK; o_q.address <= rd_start;
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + 1'b1; state_q <= S_GRD;
					end
				end
				S_APP: begin
					if (blk_cnt_q == MAXB || over) o_q.status <= ST_NOMEM;
					else begin
						o_q.status <= ST_OK; o_q.address <= wd_start;
						heap_used_q <= reach[31:0];
						blk_cnt_q <= blk_cnt_q + 1'b1;
						used_bytes_q <= used_bytes_q + need_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (r_q.req_type == REQ_FREE && o_q.status == ST_OK) begin
						free_cnt_q <= free_cnt_q + 1'b1;
						free_bytes_q <= free_bytes_q + ksize_q;
					end
					state_q <= S_OUT;
					// mover job settles here
					if (grant_q && o_q.status == ST_OK) begin
						if (r_q.req_type == REQ_CALLOC) begin
							o_q.mover_op <= MOV_ZERO; o_q.mover_len <= need_q;
						end else if (r_q.req_type == REQ_REALLOC && r_q.handle != 0) begin
							o_q.mover_op <= MOV_COPY; o_q.mover_src <= r_q.handle;
							o_q.mover_len <= ksize_q;
							grant_q <= 1'b0;
							state_q <= S_FIN;
						end
					end else if (!grant_q && o_q.mover_op == MOV_COPY) begin
						free_cnt_q <= free_cnt_q + 1'b1;
						free_bytes_q <= free_bytes_q + ksize_q;
					end
					if (grant_q && o_q.status != ST_OK) o_q.address <= '0;
				end
				S_OUT: begin
					o_q.free_blocks <= 9'(free_cnt_q);
					o_q.free_bytes  <= free_bytes_q;
					o_q.used_blocks <= 9'(blk_cnt_q);
					o_q.used_bytes  <= used_bytes_q;
					o_q.meta_bytes  <= 32'(blk_cnt_q) * HDR[31:0];
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/core/ffba_mul.sv */
// Multi-cycle shift-add multiplier: 32x32 to 64 bits, two bits per cycle.
module ffba_mul import ffba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [63:0] prod
);
	logic [63:0] acc_q;
	logic [63:0] mcand_q;
	logic [31:0] mplier_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [63:0] step;

	always_comb begin
		step = acc_q;
		if (mplier_q[0]) step = step + mcand_q;
		if (mplier_q[1]) step = step + {mcand_q[62:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= {32'd0, a};
			mplier_q <= b;
		end else if (busy_q) begin
			acc_q    <= step;
			mcand_q  <= {mcand_q[61:0], 2'b00};
			mplier_q <= {2'b00, mplier_q[31:2]};
		end
	end

	assign prod = acc_q;
endmodule

/* rtl/core/ffba_checker.sv */
// Checker: port-level properties of the allocator, bound to the top level.
module ffba_checker import ffba_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_word_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped while stalled");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while response pending");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready after accept");
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |-> rsp_data.address == 0 &&
		rsp_data.mover_op == MOV_NONE)
		else $error("failed request carries address or job");
endmodule

bind first_fit_block_allocator_top ffba_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
